/* src/cfp_pkg.sv */
// Shared types and codes for the checksummed frame parser.
// No dependencies; imported by every module of the block.
package cfp_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_SENDER  = 3'd2;
   localparam logic [2:0] PH_MSGID   = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CKA     = 3'd5;
   localparam logic [2:0] PH_CKB     = 3'd6;

   // Event codes reported with each word
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_PAYLOAD = 3'd1;
   localparam logic [2:0] EV_GOOD    = 3'd2;
   localparam logic [2:0] EV_CKERR   = 3'd3;
   localparam logic [2:0] EV_BADLEN  = 3'd4;

   // Header and trailer bytes counted in the length byte
   localparam logic [7:0] OVERHEAD = 8'd6;

   localparam logic [7:0] START_BYTE_RESET = 8'd153;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  frame_payload_len;
      logic [7:0]  payload_count;
      logic [7:0]  held_sender;
      logic [7:0]  held_msgid;
      logic [15:0] error_count;
   } state_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  payload_length;
      logic [7:0]  sender_id;
      logic [7:0]  message_id;
      logic [15:0] error_total;
   } result_type;

endpackage

/* src/cfp_step.sv */
// Per-byte parser update: next state and result word from current state and byte.
// Depends on cfp_pkg.
module cfp_step (
   input  cfp_pkg::state_type  state_cur,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          start_byte,
   output cfp_pkg::state_type  state_nxt,
   output cfp_pkg::result_type result
);
   import cfp_pkg::*;

   logic [7:0] sum_a_add;
   logic [7:0] sum_b_add;
   logic [7:0] count_inc;
   logic [2:0] event_code;
   logic [7:0] pbyte;
   logic [7:0] pidx;

   // Fletcher running sums with this byte folded in
   assign sum_a_add = state_cur.sum_a + rx_byte;
   assign sum_b_add = state_cur.sum_b + sum_a_add;
   assign count_inc = state_cur.payload_count + 8'd1;

   // Advance the phase machine
   always_comb begin
      state_nxt  = state_cur;
      event_code = EV_NONE;
      pbyte      = 8'd0;
      pidx       = 8'd0;
      case (state_cur.phase)
         PH_LEN: begin
            if (rx_byte < OVERHEAD) begin
               state_nxt.frame_payload_len = 8'd0;
               state_nxt.error_count       = state_cur.error_count + 16'd1;
               event_code                  = EV_BADLEN;
               state_nxt.phase             = PH_HUNT;
            end else begin
               state_nxt.frame_payload_len = rx_byte - OVERHEAD;
               state_nxt.payload_count     = 8'd0;
               state_nxt.sum_a             = sum_a_add;
               state_nxt.sum_b             = sum_b_add;
               state_nxt.phase             = PH_SENDER;
            end
         end
         PH_SENDER: begin
            state_nxt.held_sender = rx_byte;
            state_nxt.sum_a       = sum_a_add;
            state_nxt.sum_b       = sum_b_add;
            state_nxt.phase       = PH_MSGID;
         end
         PH_MSGID: begin
            state_nxt.held_msgid = rx_byte;
            state_nxt.sum_a      = sum_a_add;
            state_nxt.sum_b      = sum_b_add;
            state_nxt.phase      = (state_cur.frame_payload_len == 8'd0) ? PH_CKA : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            event_code              = EV_PAYLOAD;
            pbyte                   = rx_byte;
            pidx                    = state_cur.payload_count;
            state_nxt.payload_count = count_inc;
            state_nxt.sum_a         = sum_a_add;
            state_nxt.sum_b         = sum_b_add;
            if (count_inc == state_cur.frame_payload_len) begin
               state_nxt.phase = PH_CKA;
            end
         end
         PH_CKA: begin
            if (rx_byte != state_cur.sum_a) begin
               state_nxt.error_count = state_cur.error_count + 16'd1;
               event_code            = EV_CKERR;
               state_nxt.phase       = PH_HUNT;
            end else begin
               state_nxt.phase = PH_CKB;
            end
         end
         PH_CKB: begin
            if (rx_byte != state_cur.sum_b) begin
               state_nxt.error_count = state_cur.error_count + 16'd1;
               event_code            = EV_CKERR;
            end else begin
               event_code = EV_GOOD;
            end
            state_nxt.phase = PH_HUNT;
         end
         default: begin
            // hunting, and the unused code behaves the same
            if (rx_byte == start_byte) begin
               state_nxt.sum_a = start_byte;
               state_nxt.sum_b = start_byte;
               state_nxt.phase = PH_LEN;
            end else begin
               state_nxt.phase = PH_HUNT;
            end
         end
      endcase
   end

   // Build the result word from the updated state
   always_comb begin
      result.event_res      = event_code;
      result.payload_byte   = pbyte;
      result.payload_index  = pidx;
      result.payload_length = state_nxt.frame_payload_len;
      result.sender_id      = state_nxt.held_sender;
      result.message_id     = state_nxt.held_msgid;
      result.error_total    = state_nxt.error_count;
   end

endmodule

/* src/cfp_out_reg.sv */
// Output register for result words, with valid/ready flow control.
// Depends on cfp_pkg.
module cfp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   output logic                load_ready,
   input  cfp_pkg::result_type load_word,
   output logic                out_valid,
   input  logic                out_ready,
   output cfp_pkg::result_type out_word
);
   import cfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type word_ff;

   // Take a new word when empty or when the held one leaves this cycle
   assign load_ready = !valid_ff || out_ready;
   assign valid_in   = load_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until a new word is loaded
   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         word_ff <= load_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* src/checksummed_frame_parser_unit.sv */
// Checksummed frame parser, top level. Uses cfp_pkg, cfp_step and cfp_out_reg.
// A result word is registered, visible in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless rsp_ready stalls the output register;
// the state update is combinational, so bytes may then arrive back to back.
// Reset: synchronous, active high; parser returns to hunting, sums, lengths,
// ids and error count clear, start byte returns to 153, output is empty.
module checksummed_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_payload_length,
   output logic [7:0]  rsp_sender_id,
   output logic [7:0]  rsp_message_id,
   output logic [15:0] rsp_error_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_start_byte
);
   import cfp_pkg::*;

   logic [7:0] start_byte_reg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_word;
   result_type out_word;
   logic       req_fire;

   // Start byte register; writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_reg_ff <= START_BYTE_RESET;
      end else begin
         if (csr_valid) begin
            start_byte_reg_ff <= csr_start_byte;
         end
      end
   end

   assign req_fire = req_valid && req_ready;

   cfp_step u_step (
      .state_cur  (state_ff),
      .rx_byte    (req_rx_byte),
      .start_byte (start_byte_reg_ff),
      .state_nxt  (state_in),
      .result     (step_word)
   );

   // Advance parser state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_HUNT, default: '0};
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   cfp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid),
      .load_ready (req_ready),
      .load_word  (step_word),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (out_word)
   );

   assign rsp_event_res      = out_word.event_res;
   assign rsp_payload_byte   = out_word.payload_byte;
   assign rsp_payload_index  = out_word.payload_index;
   assign rsp_payload_length = out_word.payload_length;
   assign rsp_sender_id      = out_word.sender_id;
   assign rsp_message_id     = out_word.message_id;
   assign rsp_error_total    = out_word.error_total;

   // Every accepted word yields a result word on the next cycle
   assert property (@(posedge clock) disable iff (reset) req_fire |=> rsp_valid)
      else $error("accepted word produced no result");

   // A non-start byte while hunting keeps the parser hunting
   assert property (@(posedge clock) disable iff (reset)
      req_fire && state_ff.phase == PH_HUNT && req_rx_byte != start_byte_reg_ff
      |=> state_ff.phase == PH_HUNT)
      else $error("left hunting without a start byte");

   // Error events bump the error count by exactly one
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (step_word.event_res == EV_CKERR || step_word.event_res == EV_BADLEN)
      |=> state_ff.error_count == 16'($past(state_ff.error_count) + 16'd1))
      else $error("error count did not advance on error");

   // A payload word always lies inside the frame payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_PAYLOAD |-> rsp_payload_index < rsp_payload_length)
      else $error("payload index beyond payload length");

endmodule
